// File: sv/nva_pkg.sv
// Shared types and constants for the note voice allocator.
package nva_pkg;

    // Fixed field widths of the stream words.
    localparam int NOTE_IN_W  = 7;
    localparam int CHAN_W     = 4;
    localparam int ELAPSED_W  = 24;
    localparam int XPOSE_W    = 8;
    localparam int DELTA_W    = XPOSE_W + 1;
    localparam int TIME_W     = 32;
    localparam int OUT_IDX_W  = 3;
    localparam int OUT_NOTE_W = 7;
    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 2;

    // Input word kinds.
    typedef enum logic [ACTION_W-1:0] {
        ACT_NOTE_OFF  = 2'd0,
        ACT_NOTE_ON   = 2'd1,
        ACT_TICK      = 2'd2,
        ACT_TRANSPOSE = 2'd3
    } action_t;

    // Result word kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ASSIGN  = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_RETUNE  = 2'd2
    } kind_t;

    // Operations of the shared adder.
    typedef enum logic {
        ALU_NOTE,
        ALU_TIME
    } alu_op_t;

    // Write enables from the sequencer to the voice table.
    typedef struct packed {
        logic we_busy;
        logic busy_val;
        logic we_note;
        logic we_chan;
        logic we_time;
    } tbl_ctl_t;

endpackage

// File: sv/nva_alu.sv
// Shared adder with note clamping and play-time saturation.
module nva_alu #(
    parameter int NOTE_COUNT = 128
) (
    input  nva_pkg::alu_op_t             op,
    input  logic [nva_pkg::TIME_W-1:0]   a,
    input  logic [nva_pkg::TIME_W-1:0]   b,
    output logic [nva_pkg::TIME_W-1:0]   y
);

    localparam int TW = nva_pkg::TIME_W;
    localparam logic [TW+1:0] NOTE_MAX = (TW+2)'(NOTE_COUNT - 1);

    logic [TW+1:0] sum;

    // Operand a is unsigned, operand b is two's complement.
    assign sum = {2'b00, a} + {{2{b[TW-1]}}, b};

    // Clamp a note to the legal range, or saturate a play time.
    always_comb begin
        case (op)
            nva_pkg::ALU_NOTE: begin
                if (sum[TW+1]) begin
                    y = '0;
                end else if (sum > NOTE_MAX) begin
                    y = NOTE_MAX[TW-1:0];
                end else begin
                    y = sum[TW-1:0];
                end
            end
            nva_pkg::ALU_TIME: begin
                y = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
            end
            default: begin
                y = sum[TW-1:0];
            end
        endcase
    end

endmodule

// File: sv/nva_voice_table.sv
// Voice table: busy flags, notes, channels and play times of all voices.
module nva_voice_table #(
    parameter int VOICE_COUNT = 8,
    parameter int NOTE_COUNT  = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [$clog2(VOICE_COUNT)-1:0]    idx,
    input  nva_pkg::tbl_ctl_t                 ctl,
    input  logic [$clog2(NOTE_COUNT)-1:0]     wr_note,
    input  logic [nva_pkg::CHAN_W-1:0]        wr_chan,
    input  logic [nva_pkg::TIME_W-1:0]        wr_time,
    output logic                              rd_busy,
    output logic [$clog2(NOTE_COUNT)-1:0]     rd_note,
    output logic [nva_pkg::CHAN_W-1:0]        rd_chan,
    output logic [nva_pkg::TIME_W-1:0]        rd_time,
    output logic [VOICE_COUNT-1:0]            busy_vec
);

    localparam int NW = $clog2(NOTE_COUNT);

    logic [VOICE_COUNT-1:0]        busy_reg;
    logic [VOICE_COUNT-1:0]        busy_next;
    logic [NW-1:0]                 note_store_reg [VOICE_COUNT];
    logic [nva_pkg::CHAN_W-1:0]    chan_store_reg [VOICE_COUNT];
    logic [nva_pkg::TIME_W-1:0]    time_store_reg [VOICE_COUNT];

    // Busy flags are the only part that reset clears.
    always_comb begin
        busy_next = busy_reg;
        if (ctl.we_busy) begin
            busy_next[idx] = ctl.busy_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Voice data is only looked at while the voice is busy.
    always_ff @(posedge aclk) begin
        if (ctl.we_note) begin
            note_store_reg[idx] <= wr_note;
        end
        if (ctl.we_chan) begin
            chan_store_reg[idx] <= wr_chan;
        end
        if (ctl.we_time) begin
            time_store_reg[idx] <= wr_time;
        end
    end

    // Single read port at the scan index.
    assign rd_busy  = busy_reg[idx];
    assign rd_note  = note_store_reg[idx];
    assign rd_chan  = chan_store_reg[idx];
    assign rd_time  = time_store_reg[idx];
    assign busy_vec = busy_reg;

endmodule

// File: sv/nva_seq.sv
// Sequencer that builds result words, scanning the table one voice per cycle unless stalled.
module nva_seq #(
    parameter int VOICE_COUNT = 8,
    parameter int NOTE_COUNT  = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input word, already unpacked
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nva_pkg::ACTION_W-1:0]      in_action,
    input  logic [nva_pkg::NOTE_IN_W-1:0]     in_note,
    input  logic [nva_pkg::CHAN_W-1:0]        in_chan,
    input  logic [nva_pkg::ELAPSED_W-1:0]     in_elapsed,
    input  logic [nva_pkg::XPOSE_W-1:0]       in_xpose,
    // Result word, unpacked
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nva_pkg::KIND_W-1:0]        out_kind,
    output logic [nva_pkg::OUT_IDX_W-1:0]     out_idx,
    output logic [nva_pkg::OUT_NOTE_W-1:0]    out_note,
    output logic [nva_pkg::CHAN_W-1:0]        out_chan,
    output logic                              out_last,
    // Voice table access
    output logic [$clog2(VOICE_COUNT)-1:0]    tbl_idx,
    output nva_pkg::tbl_ctl_t                 tbl_ctl,
    output logic [$clog2(NOTE_COUNT)-1:0]     tbl_wr_note,
    output logic [nva_pkg::CHAN_W-1:0]        tbl_wr_chan,
    output logic [nva_pkg::TIME_W-1:0]        tbl_wr_time,
    input  logic                              tbl_rd_busy,
    input  logic [$clog2(NOTE_COUNT)-1:0]     tbl_rd_note,
    input  logic [nva_pkg::CHAN_W-1:0]        tbl_rd_chan,
    input  logic [nva_pkg::TIME_W-1:0]        tbl_rd_time,
    input  logic [VOICE_COUNT-1:0]            tbl_busy_vec,
    // Shared adder
    output nva_pkg::alu_op_t                  alu_op,
    output logic [nva_pkg::TIME_W-1:0]        alu_a,
    output logic [nva_pkg::TIME_W-1:0]        alu_b,
    input  logic [nva_pkg::TIME_W-1:0]        alu_y
);

    localparam int VW  = $clog2(VOICE_COUNT);
    localparam int NW  = $clog2(NOTE_COUNT);
    localparam int TW  = nva_pkg::TIME_W;
    localparam int XW  = nva_pkg::XPOSE_W;
    localparam int DW  = nva_pkg::DELTA_W;
    localparam int EW  = nva_pkg::ELAPSED_W;
    localparam int CW  = nva_pkg::CHAN_W;
    localparam int NIW = nva_pkg::NOTE_IN_W;
    localparam int OIW = nva_pkg::OUT_IDX_W;
    localparam int ONW = nva_pkg::OUT_NOTE_W;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_OFF_SCAN,
        ST_FREE_SCAN,
        ST_NOTE_SCAN,
        ST_CHAN_SCAN,
        ST_STEAL_SCAN,
        ST_ASSIGN,
        ST_TICK_SCAN,
        ST_XPOSE_SCAN
    } state_t;

    state_t                  state_reg,    state_next;
    nva_pkg::action_t        act_reg,      act_next;
    logic [NIW-1:0]          note_in_reg,  note_in_next;
    logic [CW-1:0]           chan_reg,     chan_next;
    logic [EW-1:0]           elapsed_reg,  elapsed_next;
    logic [XW-1:0]           offset_reg,   offset_next;
    logic [DW-1:0]           delta_reg,    delta_next;
    logic [NW-1:0]           note_reg,     note_next;
    logic [VW-1:0]           rot_reg,      rot_next;
    logic [VW-1:0]           idx_reg,      idx_next;
    logic [VW-1:0]           cnt_reg,      cnt_next;
    logic [TW-1:0]           best_reg,     best_next;
    logic [VW-1:0]           best_idx_reg, best_idx_next;
    logic                    m_valid_reg,  m_valid_next;
    nva_pkg::kind_t          m_kind_reg,   m_kind_next;
    logic [OIW-1:0]          m_idx_reg,    m_idx_next;
    logic [ONW-1:0]          m_note_reg,   m_note_next;
    logic [CW-1:0]           m_chan_reg,   m_chan_next;
    logic                    m_last_reg,   m_last_next;

    logic                    out_free;
    logic                    out_load;
    logic                    scan_done;
    logic [VW-1:0]           idx_inc;
    logic [VW-1:0]           rot_inc;
    logic [VOICE_COUNT-1:0]  busy_above;
    logic                    steal_better;

    // The result register can take a new word when empty or being drained.
    assign out_free     = !m_valid_reg || m_tready;
    assign scan_done    = (cnt_reg == LAST_VOICE);
    assign idx_inc      = (idx_reg == LAST_VOICE) ? '0 : idx_reg + 1'b1;
    assign rot_inc      = (rot_reg == LAST_VOICE) ? '0 : rot_reg + 1'b1;
    assign busy_above   = (tbl_busy_vec >> idx_reg) >> 1;
    assign steal_better = (tbl_rd_time > best_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign tbl_idx  = idx_reg;

    // Operand selection for the shared adder.
    always_comb begin
        alu_op = nva_pkg::ALU_NOTE;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            ST_CALC: begin
                alu_a = {{(TW-NIW){1'b0}}, note_in_reg};
                alu_b = {{(TW-XW){offset_reg[XW-1]}}, offset_reg};
            end
            ST_TICK_SCAN: begin
                alu_op = nva_pkg::ALU_TIME;
                alu_a  = tbl_rd_time;
                alu_b  = {{(TW-EW){1'b0}}, elapsed_reg};
            end
            ST_XPOSE_SCAN: begin
                alu_a = {{(TW-NW){1'b0}}, tbl_rd_note};
                alu_b = {{(TW-DW){delta_reg[DW-1]}}, delta_reg};
            end
            default: begin
                alu_op = nva_pkg::ALU_NOTE;
            end
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        note_in_next  = note_in_reg;
        chan_next     = chan_reg;
        elapsed_next  = elapsed_reg;
        offset_next   = offset_reg;
        delta_next    = delta_reg;
        note_next     = note_reg;
        rot_next      = rot_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        m_valid_next  = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_idx_next    = m_idx_reg;
        m_note_next   = m_note_reg;
        m_chan_next   = m_chan_reg;
        m_last_next   = m_last_reg;
        out_load      = 1'b0;
        tbl_ctl       = '0;
        tbl_wr_note   = note_reg;
        tbl_wr_chan   = chan_reg;
        tbl_wr_time   = '0;

        case (state_reg)
            // Take a word and set up the matching scan.
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next     = nva_pkg::action_t'(in_action);
                    note_in_next = in_note;
                    chan_next    = in_chan;
                    elapsed_next = in_elapsed;
                    idx_next     = '0;
                    cnt_next     = '0;
                    case (nva_pkg::action_t'(in_action))
                        nva_pkg::ACT_NOTE_OFF,
                        nva_pkg::ACT_NOTE_ON: begin
                            state_next = ST_CALC;
                        end
                        nva_pkg::ACT_TICK: begin
                            state_next = ST_TICK_SCAN;
                        end
                        nva_pkg::ACT_TRANSPOSE: begin
                            delta_next  = {in_xpose[XW-1], in_xpose}
                                        - {offset_reg[XW-1], offset_reg};
                            offset_next = in_xpose;
                            state_next  = ST_XPOSE_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Transpose and clamp the incoming note.
            ST_CALC: begin
                note_next = NW'(alu_y);
                cnt_next  = '0;
                if (act_reg == nva_pkg::ACT_NOTE_OFF) begin
                    idx_next   = '0;
                    state_next = ST_OFF_SCAN;
                end else begin
                    idx_next   = rot_reg;
                    state_next = ST_FREE_SCAN;
                end
            end

            // Release the lowest busy voice holding this note and channel.
            ST_OFF_SCAN: begin
                if (tbl_rd_busy && tbl_rd_note == note_reg && tbl_rd_chan == chan_reg) begin
                    if (out_free) begin
                        tbl_ctl.we_busy  = 1'b1;
                        tbl_ctl.busy_val = 1'b0;
                        out_load         = 1'b1;
                        m_kind_next      = nva_pkg::KIND_RELEASE;
                        m_idx_next       = OIW'(idx_reg);
                        m_note_next      = ONW'(tbl_rd_note);
                        m_chan_next      = tbl_rd_chan;
                        m_last_next      = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end else if (scan_done) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // First pass from the rotation pointer: a free voice.
            ST_FREE_SCAN: begin
                if (!tbl_rd_busy) begin
                    rot_next   = rot_inc;
                    state_next = ST_ASSIGN;
                end else if (scan_done) begin
                    idx_next   = rot_reg;
                    cnt_next   = '0;
                    state_next = ST_NOTE_SCAN;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Second pass: a voice already holding the same note.
            ST_NOTE_SCAN: begin
                if (tbl_rd_note == note_reg) begin
                    rot_next   = rot_inc;
                    state_next = ST_ASSIGN;
                end else if (scan_done) begin
                    idx_next   = rot_reg;
                    cnt_next   = '0;
                    state_next = ST_CHAN_SCAN;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Third pass: a voice on the same channel.
            ST_CHAN_SCAN: begin
                if (tbl_rd_chan == chan_reg) begin
                    rot_next   = rot_inc;
                    state_next = ST_ASSIGN;
                end else if (scan_done) begin
                    idx_next      = '0;
                    cnt_next      = '0;
                    best_next     = '0;
                    best_idx_next = '0;
                    state_next    = ST_STEAL_SCAN;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Steal the longest-playing voice; the lowest index wins a tie.
            ST_STEAL_SCAN: begin
                if (steal_better) begin
                    best_next     = tbl_rd_time;
                    best_idx_next = idx_reg;
                end
                if (scan_done) begin
                    idx_next   = steal_better ? idx_reg : best_idx_reg;
                    state_next = ST_ASSIGN;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Load the chosen voice and report it.
            ST_ASSIGN: begin
                if (out_free) begin
                    tbl_ctl.we_busy  = 1'b1;
                    tbl_ctl.busy_val = 1'b1;
                    tbl_ctl.we_note  = 1'b1;
                    tbl_ctl.we_chan  = 1'b1;
                    tbl_ctl.we_time  = 1'b1;
                    out_load         = 1'b1;
                    m_kind_next      = nva_pkg::KIND_ASSIGN;
                    m_idx_next       = OIW'(idx_reg);
                    m_note_next      = ONW'(note_reg);
                    m_chan_next      = chan_reg;
                    m_last_next      = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            // Age every busy voice, saturating.
            ST_TICK_SCAN: begin
                if (tbl_rd_busy) begin
                    tbl_ctl.we_time = 1'b1;
                    tbl_wr_time     = alu_y;
                end
                if (scan_done) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Retune every busy voice in index order, one word each.
            ST_XPOSE_SCAN: begin
                if (!tbl_rd_busy || out_free) begin
                    if (tbl_rd_busy) begin
                        tbl_ctl.we_note = 1'b1;
                        tbl_wr_note     = NW'(alu_y);
                        out_load        = 1'b1;
                        m_kind_next     = nva_pkg::KIND_RETUNE;
                        m_idx_next      = OIW'(idx_reg);
                        m_note_next     = ONW'(NW'(alu_y));
                        m_chan_next     = tbl_rd_chan;
                        m_last_next     = (busy_above == '0);
                    end
                    if (scan_done) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            offset_reg  <= '0;
            rot_reg     <= '0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            rot_reg     <= rot_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        note_in_reg  <= note_in_next;
        chan_reg     <= chan_next;
        elapsed_reg  <= elapsed_next;
        delta_reg    <= delta_next;
        note_reg     <= note_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        m_kind_reg   <= m_kind_next;
        m_idx_reg    <= m_idx_next;
        m_note_reg   <= m_note_next;
        m_chan_reg   <= m_chan_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign out_kind = m_kind_reg;
    assign out_idx  = m_idx_reg;
    assign out_note = m_note_reg;
    assign out_chan = m_chan_reg;
    assign out_last = m_last_reg;

    // A new result word never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_tready))
        else $error("result word overwritten while waiting");

    // An accepted word always takes ready low.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an accepted word");

    // The rotation pointer and the scan index stay within the voice count.
    a_rot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rot_reg <= LAST_VOICE) && (idx_reg <= LAST_VOICE))
        else $error("voice pointer out of range");

    // Assign and release words are always the final word of their input.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == nva_pkg::KIND_ASSIGN
                         || m_kind_reg == nva_pkg::KIND_RELEASE)) |-> m_last_reg)
        else $error("assign or release word without last flag");

    // The rotation pointer only moves on the way into the assign step.
    a_rot_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (rot_reg != $past(rot_reg)) |-> (state_reg == ST_ASSIGN))
        else $error("rotation pointer moved outside a voice search hit");

endmodule

// File: sv/note_voice_allocator.sv
// Note voice allocator: an input word is worked on in scan passes over the V voices, with V
// the voice count. A note-on needs up to three round-robin passes (free voice, same note,
// same channel) and one steal pass, a note-off up to one pass, and a tick or a transpose
// exactly one pass, because a single voice-table read port and one shared adder handle one
// voice per cycle while no result is waiting to drain. The input is not ready while a word
// is being worked on; results wait in a one-word output register, and an assign, a release
// or a retune step stalls while that register is full.
module note_voice_allocator #(
    parameter int VOICE_COUNT = 8,
    parameter int NOTE_COUNT  = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // note_number[6:0], channel_number[10:7], elapsed_time[34:11],
    // transpose_value[42:35], zero[47:43]
    input  logic [47:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // voice_index[2:0], voice_note[9:3], voice_channel[13:10], zero[15:14]
    output logic [15:0] m_tdata,
    // update_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int VW = $clog2(VOICE_COUNT);
    localparam int NW = $clog2(NOTE_COUNT);

    logic [nva_pkg::KIND_W-1:0]      out_kind;
    logic [nva_pkg::OUT_IDX_W-1:0]   out_idx;
    logic [nva_pkg::OUT_NOTE_W-1:0]  out_note;
    logic [nva_pkg::CHAN_W-1:0]      out_chan;

    logic [VW-1:0]                   tbl_idx;
    nva_pkg::tbl_ctl_t               tbl_ctl;
    logic [NW-1:0]                   tbl_wr_note;
    logic [nva_pkg::CHAN_W-1:0]      tbl_wr_chan;
    logic [nva_pkg::TIME_W-1:0]      tbl_wr_time;
    logic                            tbl_rd_busy;
    logic [NW-1:0]                   tbl_rd_note;
    logic [nva_pkg::CHAN_W-1:0]      tbl_rd_chan;
    logic [nva_pkg::TIME_W-1:0]      tbl_rd_time;
    logic [VOICE_COUNT-1:0]          tbl_busy_vec;

    nva_pkg::alu_op_t                alu_op;
    logic [nva_pkg::TIME_W-1:0]      alu_a;
    logic [nva_pkg::TIME_W-1:0]      alu_b;
    logic [nva_pkg::TIME_W-1:0]      alu_y;

    // Sequencer with the input fields unpacked from the stream word.
    nva_seq #(
        .VOICE_COUNT (VOICE_COUNT),
        .NOTE_COUNT  (NOTE_COUNT)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .in_action    (s_tuser),
        .in_note      (s_tdata[6:0]),
        .in_chan      (s_tdata[10:7]),
        .in_elapsed   (s_tdata[34:11]),
        .in_xpose     (s_tdata[42:35]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_kind     (out_kind),
        .out_idx      (out_idx),
        .out_note     (out_note),
        .out_chan     (out_chan),
        .out_last     (m_tlast),
        .tbl_idx      (tbl_idx),
        .tbl_ctl      (tbl_ctl),
        .tbl_wr_note  (tbl_wr_note),
        .tbl_wr_chan  (tbl_wr_chan),
        .tbl_wr_time  (tbl_wr_time),
        .tbl_rd_busy  (tbl_rd_busy),
        .tbl_rd_note  (tbl_rd_note),
        .tbl_rd_chan  (tbl_rd_chan),
        .tbl_rd_time  (tbl_rd_time),
        .tbl_busy_vec (tbl_busy_vec),
        .alu_op       (alu_op),
        .alu_a        (alu_a),
        .alu_b        (alu_b),
        .alu_y        (alu_y)
    );

    // Voice state storage.
    nva_voice_table #(
        .VOICE_COUNT (VOICE_COUNT),
        .NOTE_COUNT  (NOTE_COUNT)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (tbl_idx),
        .ctl      (tbl_ctl),
        .wr_note  (tbl_wr_note),
        .wr_chan  (tbl_wr_chan),
        .wr_time  (tbl_wr_time),
        .rd_busy  (tbl_rd_busy),
        .rd_note  (tbl_rd_note),
        .rd_chan  (tbl_rd_chan),
        .rd_time  (tbl_rd_time),
        .busy_vec (tbl_busy_vec)
    );

    // Shared adder for note clamping and play-time aging.
    nva_alu #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Pack the result word.
    assign m_tdata = {2'b00, out_chan, out_note, out_idx};
    assign m_tuser = out_kind;

endmodule
